### rtl/xmcr_pkg.sv
package xmcr_pkg;

  // Packet geometry.
  localparam int unsigned DATA_BYTES       = 128;
  localparam int unsigned WRITE_WORD_BYTES = 8;
  localparam int unsigned PKT_LAST         = DATA_BYTES + 3;
  localparam int unsigned WORD_ROWS        =
      (DATA_BYTES + WRITE_WORD_BYTES - 1) / WRITE_WORD_BYTES;
  localparam int unsigned LAST_ROW_BYTES   =
      DATA_BYTES - (WORD_ROWS - 1) * WRITE_WORD_BYTES;
  localparam int unsigned WORD_W           = 8 * WRITE_WORD_BYTES;
  localparam int unsigned ROW_W            = (WORD_ROWS > 1) ? $clog2(WORD_ROWS) : 1;
  localparam int unsigned COL_W            =
      (WRITE_WORD_BYTES > 1) ? $clog2(WRITE_WORD_BYTES) : 1;
  localparam int unsigned POS_W            = $clog2(PKT_LAST + 1);

  // Input operations.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_FLASH = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Finish codes.
  localparam logic [1:0] END_JUMP     = 2'd0;
  localparam logic [1:0] END_APP_FAIL = 2'd1;
  localparam logic [1:0] END_ABORT    = 2'd2;
  localparam logic [1:0] END_NO_START = 2'd3;

  // Link bytes.
  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;

  // Application check.
  localparam logic [7:0] APP_MARK_A = 8'h82;
  localparam logic [7:0] APP_MARK_B = 8'hAC;
  localparam logic [7:0] JUMP_FLAG  = 8'hA5;
  localparam logic [8:0] BLOCK_PAIR_SUM = 9'h0FF;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_START = 1'b0;
  localparam logic CFG_PRIOR_FIRST = 1'b1;

  localparam logic [23:0] IMAGE_START_RESET = 24'd32768;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [23:0] flash_addr;
    logic [63:0] flash_data;
    logic [3:0]  flash_bytes;
    logic [1:0]  end_code;
    logic        result_last;
  } out_t;

endpackage

### rtl/xmcr_buf.sv
// Packet data buffer, organized as rows of one flash word each. Every byte
// has a valid bit so that bytes never written since reset read as zero.
module xmcr_buf (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [xmcr_pkg::ROW_W-1:0]         wr_row_i,
  input  logic [xmcr_pkg::COL_W-1:0]         wr_col_i,
  input  logic [7:0]                         wr_byte_i,
  input  logic [xmcr_pkg::ROW_W-1:0]         rd_row_i,
  output logic [xmcr_pkg::WORD_W-1:0]        rd_word_o
);

  logic [xmcr_pkg::WORD_W-1:0]           mem_q [xmcr_pkg::WORD_ROWS];
  logic [xmcr_pkg::WRITE_WORD_BYTES-1:0] vld_q [xmcr_pkg::WORD_ROWS];
  logic [xmcr_pkg::WORD_W-1:0]           rd_data_q;
  logic [xmcr_pkg::WRITE_WORD_BYTES-1:0] rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i][wr_col_i*8 +: 8] <= wr_byte_i;
    end
    rd_data_q <= mem_q[rd_row_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < xmcr_pkg::WORD_ROWS; r++) begin
        vld_q[r] <= '0;
      end
      rd_vld_q <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_row_i][wr_col_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_row_i];
    end
  end

  always_comb begin
    for (int j = 0; j < xmcr_pkg::WRITE_WORD_BYTES; j++) begin
      rd_word_o[j*8 +: 8] = rd_vld_q[j] ? rd_data_q[j*8 +: 8] : 8'h00;
    end
  end

endmodule

### rtl/xmodem_checksum_receiver.sv
// XMODEM receiver with an 8-bit additive checksum that turns a download into
// flash word writes. Input beats are taken while the sequencer is idle; any
// beat but the last beat of a packet or an EOT between packets gives at most
// one result, which waits in the output register while the next beat is
// already taken. The last beat of a packet runs a checksum pass over the
// packet buffer, one flash word row per cycle through its one read port. An
// accepted packet then drains its words through the same port, each word
// read through the registered port before it is sent, followed by ACK; the
// drain waits while the output stalls. EOT gives up to three results, one per
// cycle while the output does not stall. The buffer needs no clearing pass:
// per-byte valid bits clear at reset.
module xmodem_checksum_receiver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  xmcr_pkg::in_t      in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output xmcr_pkg::out_t     out_o
);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_WAIT_SOH = 2'd1;
  localparam logic [1:0] PH_PACKET   = 2'd2;
  localparam logic [1:0] PH_BETWEEN  = 2'd3;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEND     = 3'd1;
  localparam logic [2:0] S_SUM_RD   = 3'd2;
  localparam logic [2:0] S_SUM_END  = 3'd3;
  localparam logic [2:0] S_WORD     = 3'd4;
  localparam logic [2:0] S_EOT_ACK  = 3'd5;
  localparam logic [2:0] S_EOT_JUMP = 3'd6;

  localparam logic [xmcr_pkg::ROW_W-1:0] LAST_ROW = xmcr_pkg::ROW_W'(xmcr_pkg::WORD_ROWS - 1);
  localparam logic [xmcr_pkg::COL_W-1:0] LAST_COL =
      xmcr_pkg::COL_W'(xmcr_pkg::WRITE_WORD_BYTES - 1);
  localparam logic [xmcr_pkg::POS_W-1:0] POS_LAST = xmcr_pkg::POS_W'(xmcr_pkg::PKT_LAST);

  function automatic xmcr_pkg::out_t mk_tx(logic [7:0] tx, logic last);
    xmcr_pkg::out_t r;
    r = '0;
    r.kind        = xmcr_pkg::KIND_TX;
    r.tx_byte     = tx;
    r.result_last = last;
    return r;
  endfunction

  function automatic xmcr_pkg::out_t mk_done(logic [1:0] code);
    xmcr_pkg::out_t r;
    r = '0;
    r.kind        = xmcr_pkg::KIND_DONE;
    r.end_code    = code;
    r.result_last = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] word_sum(logic [xmcr_pkg::WORD_W-1:0] w);
    logic [7:0] s;
    s = 8'h00;
    for (int j = 0; j < xmcr_pkg::WRITE_WORD_BYTES; j++) begin
      s = s + w[j*8 +: 8];
    end
    return s;
  endfunction

  logic [23:0] image_start_q;
  logic [7:0]  prior_first_q;

  logic [1:0]                  phase_q;
  logic [xmcr_pkg::POS_W-1:0]  pos_q;
  logic [7:0]                  exp_block_q;
  logic [7:0]                  block_q;
  logic [7:0]                  compl_q;
  logic [7:0]                  check_q;
  logic [23:0]                 waddr_q;
  logic [7:0]                  first_byte_q;
  logic                        first_valid_q;

  logic [2:0]                  state_q;
  logic [xmcr_pkg::ROW_W-1:0]  row_q;
  logic                        rdv_q;
  logic [7:0]                  sum_q;
  logic [23:0]                 faddr_q;
  logic                        jump_q;
  xmcr_pkg::out_t              pend_q;
  logic [xmcr_pkg::COL_W-1:0]  wr_col_q;
  logic [xmcr_pkg::ROW_W-1:0]  wr_row_q;

  xmcr_pkg::out_t              out_q;
  logic                        out_valid_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        buf_we;
  logic                        in_data_pos;
  logic [xmcr_pkg::WORD_W-1:0] rd_word;
  logic [7:0]                  sum_acc;
  logic                        pkt_ok;
  logic [7:0]                  first_sel;
  logic                        app_ok;
  logic                        last_row;
  xmcr_pkg::out_t              word_res;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign in_data_pos = (pos_q >= xmcr_pkg::POS_W'(3)) && (pos_q < POS_LAST);
  assign buf_we      = in_acc && (in_i.op == xmcr_pkg::OP_BYTE) &&
                       (phase_q == PH_PACKET) && in_data_pos;

  xmcr_buf u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (buf_we),
    .wr_row_i  (wr_row_q),
    .wr_col_i  (wr_col_q),
    .wr_byte_i (in_i.rx_byte),
    .rd_row_i  (row_q),
    .rd_word_o (rd_word)
  );

  assign sum_acc = sum_q + word_sum(rd_word);
  assign pkt_ok  = (({1'b0, block_q} + {1'b0, compl_q}) == xmcr_pkg::BLOCK_PAIR_SUM) &&
                   (block_q == exp_block_q) && (sum_acc == check_q);

  assign first_sel = first_valid_q ? first_byte_q : prior_first_q;
  assign app_ok    = first_sel inside {xmcr_pkg::APP_MARK_A, xmcr_pkg::APP_MARK_B};
  assign last_row  = (row_q == LAST_ROW);

  always_comb begin
    word_res             = '0;
    word_res.kind        = xmcr_pkg::KIND_FLASH;
    word_res.flash_addr  = faddr_q;
    word_res.flash_data  = 64'(rd_word);
    word_res.flash_bytes = last_row ? 4'(xmcr_pkg::LAST_ROW_BYTES)
                                    : 4'(xmcr_pkg::WRITE_WORD_BYTES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_start_q <= xmcr_pkg::IMAGE_START_RESET;
      prior_first_q <= 8'h00;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        xmcr_pkg::CFG_IMAGE_START: image_start_q <= cfg_data_i;
        xmcr_pkg::CFG_PRIOR_FIRST: prior_first_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      pos_q         <= '0;
      exp_block_q   <= 8'h01;
      block_q       <= 8'h00;
      compl_q       <= 8'h00;
      check_q       <= 8'h00;
      waddr_q       <= xmcr_pkg::IMAGE_START_RESET;
      first_byte_q  <= 8'h00;
      first_valid_q <= 1'b0;
      state_q       <= S_IDLE;
      row_q         <= '0;
      rdv_q         <= 1'b0;
      sum_q         <= 8'h00;
      faddr_q       <= '0;
      jump_q        <= 1'b0;
      pend_q        <= '0;
      wr_col_q      <= '0;
      wr_row_q      <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.op == xmcr_pkg::OP_START) begin
              phase_q       <= PH_WAIT_SOH;
              pos_q         <= '0;
              exp_block_q   <= 8'h01;
              waddr_q       <= image_start_q;
              first_valid_q <= 1'b0;
              pend_q        <= mk_tx(xmcr_pkg::NAK_BYTE, 1'b1);
              state_q       <= S_SEND;
            end else if (in_i.op != xmcr_pkg::OP_BYTE && in_i.op != xmcr_pkg::OP_TIMEOUT) begin
              // Undefined operation: nothing happens.
            end else begin
              case (phase_q)
                PH_WAIT_SOH: begin
                  if (in_i.op == xmcr_pkg::OP_BYTE && in_i.rx_byte == xmcr_pkg::SOH_BYTE) begin
                    phase_q <= PH_PACKET;
                    pos_q   <= xmcr_pkg::POS_W'(1);
                  end else begin
                    phase_q <= PH_IDLE;
                    pend_q  <= mk_done(xmcr_pkg::END_NO_START);
                    state_q <= S_SEND;
                  end
                end
                PH_PACKET: begin
                  if (in_i.op == xmcr_pkg::OP_BYTE) begin
                    if (pos_q == xmcr_pkg::POS_W'(1)) begin
                      block_q <= in_i.rx_byte;
                    end else if (pos_q == xmcr_pkg::POS_W'(2)) begin
                      compl_q <= in_i.rx_byte;
                    end else if (pos_q == POS_LAST) begin
                      check_q <= in_i.rx_byte;
                    end
                  end
                  // A timeout advances the position just like a byte does.
                  if (pos_q == xmcr_pkg::POS_W'(2)) begin
                    wr_col_q <= '0;
                    wr_row_q <= '0;
                  end else if (in_data_pos) begin
                    if (wr_col_q == LAST_COL) begin
                      wr_col_q <= '0;
                      wr_row_q <= xmcr_pkg::ROW_W'(wr_row_q + 1'b1);
                    end else begin
                      wr_col_q <= xmcr_pkg::COL_W'(wr_col_q + 1'b1);
                    end
                  end
                  if (pos_q >= POS_LAST) begin
                    phase_q <= PH_BETWEEN;
                    row_q   <= '0;
                    rdv_q   <= 1'b0;
                    sum_q   <= 8'h00;
                    state_q <= S_SUM_RD;
                  end else begin
                    pos_q <= xmcr_pkg::POS_W'(pos_q + 1'b1);
                  end
                end
                PH_BETWEEN: begin
                  if (in_i.op == xmcr_pkg::OP_BYTE) begin
                    if (in_i.rx_byte == xmcr_pkg::SOH_BYTE) begin
                      phase_q <= PH_PACKET;
                      pos_q   <= xmcr_pkg::POS_W'(1);
                    end else if (in_i.rx_byte == xmcr_pkg::EOT_BYTE) begin
                      phase_q <= PH_IDLE;
                      jump_q  <= app_ok;
                      state_q <= S_EOT_ACK;
                    end else begin
                      phase_q <= PH_IDLE;
                      pend_q  <= mk_done(xmcr_pkg::END_ABORT);
                      state_q <= S_SEND;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end

        S_SEND: begin
          if (out_free) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        // One buffer row is read per cycle; its registered data is summed in the following cycle.
        S_SUM_RD: begin
          if (rdv_q) begin
            sum_q <= sum_acc;
          end
          rdv_q <= 1'b1;
          if (last_row) begin
            state_q <= S_SUM_END;
          end else begin
            row_q <= xmcr_pkg::ROW_W'(row_q + 1'b1);
          end
        end

        S_SUM_END: begin
          row_q   <= '0;
          rdv_q   <= 1'b0;
          faddr_q <= waddr_q;
          if (pkt_ok) begin
            exp_block_q <= exp_block_q + 8'h01;
            state_q     <= S_WORD;
          end else begin
            pend_q  <= mk_tx(xmcr_pkg::NAK_BYTE, 1'b1);
            state_q <= S_SEND;
          end
        end

        // The read address holds on the current row until its word is sent.
        S_WORD: begin
          rdv_q <= 1'b1;
          if (rdv_q && out_free) begin
            out_q       <= word_res;
            out_valid_q <= 1'b1;
            rdv_q       <= 1'b0;
            faddr_q     <= faddr_q + 24'(xmcr_pkg::WRITE_WORD_BYTES);
            if (row_q == '0 && !first_valid_q) begin
              first_byte_q  <= rd_word[7:0];
              first_valid_q <= 1'b1;
            end
            if (last_row) begin
              waddr_q <= waddr_q + 24'(xmcr_pkg::DATA_BYTES);
              pend_q  <= mk_tx(xmcr_pkg::ACK_BYTE, 1'b1);
              state_q <= S_SEND;
            end else begin
              row_q <= xmcr_pkg::ROW_W'(row_q + 1'b1);
            end
          end
        end

        S_EOT_ACK: begin
          if (out_free) begin
            out_q       <= mk_tx(xmcr_pkg::ACK_BYTE, 1'b0);
            out_valid_q <= 1'b1;
            if (jump_q) begin
              state_q <= S_EOT_JUMP;
            end else begin
              pend_q  <= mk_done(xmcr_pkg::END_APP_FAIL);
              state_q <= S_SEND;
            end
          end
        end

        S_EOT_JUMP: begin
          if (out_free) begin
            out_q             <= '0;
            out_q.kind        <= xmcr_pkg::KIND_FLASH;
            out_q.flash_addr  <= image_start_q - 24'd1;
            out_q.flash_data  <= 64'(xmcr_pkg::JUMP_FLAG);
            out_q.flash_bytes <= 4'd1;
            out_valid_q       <= 1'b1;
            pend_q            <= mk_done(xmcr_pkg::END_JUMP);
            state_q           <= S_SEND;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The sequencer only leaves idle when a beat is taken.
  a_idle_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && !in_acc |=> (state_q == S_IDLE))
    else $error("sequencer left idle without an input beat");

  // Packet drain happens only between packets.
  a_word_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WORD) |-> (phase_q == PH_BETWEEN))
    else $error("flash words drained outside the between-packets phase");

  // A flash write carries between one and one word of bytes.
  a_flash_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind == xmcr_pkg::KIND_FLASH) |->
      (out_o.flash_bytes != 4'd0) &&
      (out_o.flash_bytes <= 4'(xmcr_pkg::WRITE_WORD_BYTES)))
    else $error("flash write with a bad byte count");

  // A finish result always closes the results of its beat.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind == xmcr_pkg::KIND_DONE) |-> out_o.result_last)
    else $error("finish result not marked last");

  // A new output is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("pending result overwritten");

endmodule
